>>> rtl/srsg_pkg.sv
// shared types and constants for the stepper ramp step generator
package srsg_pkg;

  localparam int MAX_PHASES_DEF = 3;
  localparam logic [31:0] TICK_PERIOD_RST = 32'd21475;

  localparam int STEPS_W = 24;
  localparam int VEL_W   = 21;
  localparam int TIME_W  = 48;
  localparam int TP_W    = 32;
  localparam int DIR_W   = 2;

  localparam int DIV_NUM_W = 72;
  localparam int DIV_DEN_W = 52;
  localparam int DIV_CNT_W = 7;

  localparam int MUL_A_W    = 47;
  localparam int MUL_DGT_W  = 16;
  localparam int MUL_DIGITS = 3;
  localparam int PROD_W     = MUL_A_W + TIME_W;
  localparam int PCAP_W     = 51;
  localparam int VQ_W       = 53;

  localparam logic [TIME_W-1:0] MAX48 = '1;
  localparam logic [TIME_W-1:0] MAXACC = {1'b0, {(TIME_W-1){1'b1}}};

  // numerator alignment and iteration counts of the three divisions
  localparam int TF_SHIFT  = 48;
  localparam logic [DIV_CNT_W-1:0] TF_BITS  = 7'd57;
  localparam int ACC_SHIFT = 50;
  localparam logic [DIV_CNT_W-1:0] ACC_BITS = 7'd70;
  localparam logic [DIV_CNT_W-1:0] IV_BITS  = 7'd49;

  typedef struct packed {
    logic signed [STEPS_W-1:0] steps;
    logic signed [VEL_W-1:0]   vi;
    logic signed [VEL_W-1:0]   vf;
  } phase_t;

  typedef struct packed {
    logic                  go;
    logic [DIV_NUM_W-1:0]  num;
    logic [DIV_CNT_W-1:0]  nbits;
    logic [DIV_DEN_W-1:0]  den;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic [DIV_NUM_W-1:0]  quo;
  } div_rsp_t;

endpackage

>>> rtl/srsg_in_if.sv
// input channel: phase loads and ticks
interface srsg_in_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  kind;
  logic                                  first_of_list;
  logic signed [srsg_pkg::STEPS_W-1:0]   phase_steps;
  logic signed [srsg_pkg::VEL_W-1:0]     start_velocity;
  logic signed [srsg_pkg::VEL_W-1:0]     end_velocity;

  modport source (output valid, kind, first_of_list, phase_steps, start_velocity,
                  end_velocity, input ready);
  modport sink (input valid, kind, first_of_list, phase_steps, start_velocity,
                end_velocity, output ready);
endinterface

>>> rtl/srsg_out_if.sv
// result channel: one word per tick
interface srsg_out_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 active;
  logic                                 step_pulse;
  logic signed [srsg_pkg::DIR_W-1:0]    direction;
  logic [srsg_pkg::STEPS_W-1:0]         steps_remaining;

  modport source (output valid, active, step_pulse, direction, steps_remaining,
                  input ready);
  modport sink (input valid, active, step_pulse, direction, steps_remaining,
                output ready);
endinterface

>>> rtl/srsg_cfg_if.sv
// configuration write channel for tick_period
interface srsg_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [srsg_pkg::TP_W-1:0]     data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

>>> rtl/srsg_div.sv
// iterative restoring divider, one quotient bit per cycle
module srsg_div (
  input  logic               clk,
  input  logic               rst_n,
  input  srsg_pkg::div_req_t req,
  output srsg_pkg::div_rsp_t rsp
);

  logic                              busy_r, busy_nxt;
  logic                              done_r, done_nxt;
  logic [srsg_pkg::DIV_CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [srsg_pkg::DIV_NUM_W-1:0]    num_r, num_nxt;
  logic [srsg_pkg::DIV_NUM_W-1:0]    quo_r, quo_nxt;
  logic [srsg_pkg::DIV_DEN_W-1:0]    den_r, den_nxt;
  logic [srsg_pkg::DIV_DEN_W-1:0]    rem_r, rem_nxt;
  logic [srsg_pkg::DIV_DEN_W:0]      r_sh;
  logic                              ge;

  assign r_sh = {rem_r, num_r[srsg_pkg::DIV_NUM_W-1]};
  assign ge   = r_sh >= {1'b0, den_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    if (req.go) begin
      busy_nxt = 1'b1;
      cnt_nxt  = req.nbits;
      num_nxt  = req.num;
      den_nxt  = req.den;
      quo_nxt  = '0;
      rem_nxt  = '0;
    end else if (busy_r) begin
      rem_nxt = ge ? srsg_pkg::DIV_DEN_W'(r_sh - {1'b0, den_r})
                   : r_sh[srsg_pkg::DIV_DEN_W-1:0];
      quo_nxt = {quo_r[srsg_pkg::DIV_NUM_W-2:0], ge};
      num_nxt = {num_r[srsg_pkg::DIV_NUM_W-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == srsg_pkg::DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    num_r <= num_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;

endmodule

>>> rtl/stepper_ramp_step_generator_unit.sv
// top level of the single-axis stepper ramp step generator
//
// channels: in_chan takes words of kind load (fills the phase list, a word
// marked first_of_list restarts it) or kind tick (advances one tick).
// out_chan gives one word per tick; a load gives none. cfg_chan writes
// tick_period and is always ready; write it only while the block is idle.
// sequence: a load is taken in the idle state. a tick runs a compare, a
// multiply of acceleration by phase time, a 49-bit pass of the shared
// divider for the step interval and an output step before the next ready.
// a tick that starts a new phase first runs a 57-bit and a 70-bit divide
// (phase time, acceleration) and one more multiply and interval divide.
// a tick after the list has run out goes straight to the output step.
// in_chan.ready is high only while the sequencer is idle; one word at a time.
// reset: all motion state clears, list empty, tick_period returns to 21475.
// stall: the result word holds in the output register until taken; a new
// word is accepted meanwhile, and its result waits for the register to free.
module stepper_ramp_step_generator_unit #(
  parameter int MAX_PHASES = srsg_pkg::MAX_PHASES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  srsg_in_if.sink     in_chan,
  srsg_out_if.source  out_chan,
  srsg_cfg_if.sink    cfg_chan
);

  localparam int IdxW = (MAX_PHASES > 1) ? $clog2(MAX_PHASES) : 1;
  localparam int CntW = $clog2(MAX_PHASES + 1);
  localparam int TW   = srsg_pkg::TIME_W;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_TF   = 7'b0000010,
    ST_ACC  = 7'b0000100,
    ST_MUL  = 7'b0001000,
    ST_IV   = 7'b0010000,
    ST_CMP  = 7'b0100000,
    ST_OUT  = 7'b1000000
  } state_t;

  state_t                               state_r, state_nxt;
  logic                                 busy_r, busy_nxt;
  logic                                 start_r, start_nxt;
  logic [1:0]                           dgt_r, dgt_nxt;
  srsg_pkg::phase_t                     store_r [MAX_PHASES];
  srsg_pkg::phase_t                     ent_r, ent_nxt;
  logic [CntW-1:0]                      pidx_r, pidx_nxt;
  logic [CntW-1:0]                      prem_r, prem_nxt;
  logic                                 fin_r, fin_nxt;
  logic [srsg_pkg::STEPS_W-1:0]         left_r, left_nxt;
  logic signed [srsg_pkg::DIR_W-1:0]    dir_r, dir_nxt;
  logic signed [TW-1:0]                 accel_r, accel_nxt;
  logic [TW-1:0]                        ptime_r, ptime_nxt;
  logic [TW-1:0]                        ival_r, ival_nxt;
  logic [TW-1:0]                        accum_r, accum_nxt;
  logic [TW-1:0]                        tf_r, tf_nxt;
  logic [TW-1:0]                        mult_r, mult_nxt;
  logic [srsg_pkg::PROD_W-1:0]          prod_r, prod_nxt;
  logic signed [srsg_pkg::VEL_W-1:0]    runvi_r, runvi_nxt;
  logic [srsg_pkg::TP_W-1:0]            tp_r;
  logic                                 act_r, act_nxt;
  logic                                 pulse_r, pulse_nxt;
  logic                                 ov_r, ov_nxt;
  logic                                 oact_r, oact_nxt;
  logic                                 opulse_r, opulse_nxt;
  logic signed [srsg_pkg::DIR_W-1:0]    odir_r, odir_nxt;
  logic [srsg_pkg::STEPS_W-1:0]         oleft_r, oleft_nxt;

  logic                                 st_we;
  logic [IdxW-1:0]                      st_wa;
  srsg_pkg::phase_t                     in_ent;
  logic [CntW:0]                        fill;

  srsg_pkg::div_req_t                   dreq;
  srsg_pkg::div_rsp_t                   drsp;

  logic [srsg_pkg::STEPS_W-1:0]         steps_mag;
  logic signed [srsg_pkg::VEL_W:0]      vsum, vdiff;
  logic [srsg_pkg::VEL_W:0]             vsum_mag, vdiff_mag;
  logic [srsg_pkg::MUL_A_W-1:0]         accel_mag;
  logic [srsg_pkg::MUL_DGT_W-1:0]       mdigit;
  logic [srsg_pkg::PCAP_W-1:0]          pcap;
  logic signed [srsg_pkg::VQ_W-1:0]     vq;
  logic [srsg_pkg::VQ_W-1:0]            vq_mag;
  logic [TW:0]                          acc_sum, pt_sum;
  logic [TW-1:0]                        acc_sat, pt_sat;
  logic [TW-1:0]                        sat_m;
  logic [TW:0]                          tf_q;

  srsg_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dreq),
    .rsp   (drsp)
  );

  assign in_chan.ready  = (state_r == ST_IDLE);
  assign cfg_chan.ready = 1'b1;

  assign out_chan.valid           = ov_r;
  assign out_chan.active          = oact_r;
  assign out_chan.step_pulse      = opulse_r;
  assign out_chan.direction       = odir_r;
  assign out_chan.steps_remaining = oleft_r;

  assign in_ent.steps = in_chan.phase_steps;
  assign in_ent.vi    = in_chan.start_velocity;
  assign in_ent.vf    = in_chan.end_velocity;
  assign fill         = {1'b0, pidx_r} + {1'b0, prem_r};

  assign steps_mag = ent_r.steps[srsg_pkg::STEPS_W-1] ?
                     srsg_pkg::STEPS_W'(-ent_r.steps) : srsg_pkg::STEPS_W'(ent_r.steps);
  assign vsum      = $signed({ent_r.vf[srsg_pkg::VEL_W-1], ent_r.vf})
                   + $signed({ent_r.vi[srsg_pkg::VEL_W-1], ent_r.vi});
  assign vdiff     = $signed({ent_r.vf[srsg_pkg::VEL_W-1], ent_r.vf})
                   - $signed({ent_r.vi[srsg_pkg::VEL_W-1], ent_r.vi});
  assign vsum_mag  = vsum[srsg_pkg::VEL_W] ? (srsg_pkg::VEL_W+1)'(-vsum)
                                           : (srsg_pkg::VEL_W+1)'(vsum);
  assign vdiff_mag = vdiff[srsg_pkg::VEL_W] ? (srsg_pkg::VEL_W+1)'(-vdiff)
                                            : (srsg_pkg::VEL_W+1)'(vdiff);

  assign accel_mag = accel_r[TW-1] ? srsg_pkg::MUL_A_W'(-accel_r)
                                   : accel_r[srsg_pkg::MUL_A_W-1:0];
  assign mdigit    = mult_r[dgt_r*srsg_pkg::MUL_DGT_W +: srsg_pkg::MUL_DGT_W];

  assign pcap = (prod_r[srsg_pkg::PROD_W-1:32] > (srsg_pkg::PROD_W-32)'(64'd1 << 50)) ?
                srsg_pkg::PCAP_W'(64'd1 << 50) : prod_r[32 +: srsg_pkg::PCAP_W];
  assign vq   = ($signed(srsg_pkg::VQ_W'(runvi_r)) <<< 16)
              + (accel_r[TW-1] ? -$signed({2'b00, pcap}) : $signed({2'b00, pcap}));
  assign vq_mag = vq[srsg_pkg::VQ_W-1] ? srsg_pkg::VQ_W'(-vq) : srsg_pkg::VQ_W'(vq);

  assign acc_sum = {1'b0, accum_r} + (TW+1)'(tp_r);
  assign acc_sat = acc_sum[TW] ? srsg_pkg::MAX48 : acc_sum[TW-1:0];
  assign pt_sum  = {1'b0, ptime_r} + (TW+1)'(tp_r);
  assign pt_sat  = pt_sum[TW] ? srsg_pkg::MAX48 : pt_sum[TW-1:0];

  assign tf_q  = (drsp.quo > srsg_pkg::DIV_NUM_W'(srsg_pkg::MAX48)) ?
                 {1'b0, srsg_pkg::MAX48} : drsp.quo[TW:0];
  assign sat_m = (drsp.quo > srsg_pkg::DIV_NUM_W'(srsg_pkg::MAXACC)) ?
                 srsg_pkg::MAXACC : drsp.quo[TW-1:0];

  always_comb begin
    state_nxt  = state_r;
    busy_nxt   = busy_r;
    start_nxt  = start_r;
    dgt_nxt    = dgt_r;
    ent_nxt    = ent_r;
    pidx_nxt   = pidx_r;
    prem_nxt   = prem_r;
    fin_nxt    = fin_r;
    left_nxt   = left_r;
    dir_nxt    = dir_r;
    accel_nxt  = accel_r;
    ptime_nxt  = ptime_r;
    ival_nxt   = ival_r;
    accum_nxt  = accum_r;
    tf_nxt     = tf_r;
    mult_nxt   = mult_r;
    prod_nxt   = prod_r;
    runvi_nxt  = runvi_r;
    act_nxt    = act_r;
    pulse_nxt  = pulse_r;
    ov_nxt     = ov_r;
    oact_nxt   = oact_r;
    opulse_nxt = opulse_r;
    odir_nxt   = odir_r;
    oleft_nxt  = oleft_r;
    st_we      = 1'b0;
    st_wa      = '0;
    dreq       = '0;

    if (ov_r && out_chan.ready) begin
      ov_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_chan.valid) begin
          if (!in_chan.kind) begin
            if (in_chan.first_of_list) begin
              st_we    = 1'b1;
              st_wa    = '0;
              pidx_nxt = '0;
              prem_nxt = CntW'(1);
              fin_nxt  = 1'b0;
            end else if (fill < (CntW+1)'(MAX_PHASES)) begin
              st_we    = 1'b1;
              st_wa    = fill[IdxW-1:0];
              prem_nxt = prem_r + 1'b1;
              fin_nxt  = 1'b0;
            end
          end else if (left_r == '0) begin
            if (fin_r || prem_r == '0) begin
              fin_nxt   = 1'b1;
              act_nxt   = 1'b0;
              pulse_nxt = 1'b0;
              state_nxt = ST_OUT;
            end else begin
              ent_nxt   = store_r[pidx_r[IdxW-1:0]];
              state_nxt = ST_TF;
            end
          end else begin
            state_nxt = ST_CMP;
          end
        end
      end

      ST_TF: begin
        if (!busy_r) begin
          if (vsum != '0) begin
            dreq.go    = 1'b1;
            dreq.num   = srsg_pkg::DIV_NUM_W'(steps_mag) << srsg_pkg::TF_SHIFT;
            dreq.nbits = srsg_pkg::TF_BITS;
            dreq.den   = srsg_pkg::DIV_DEN_W'(vsum_mag);
            busy_nxt   = 1'b1;
          end else begin
            tf_nxt    = '0;
            state_nxt = ST_ACC;
          end
        end else if (drsp.done) begin
          tf_nxt    = tf_q[TW-1:0];
          busy_nxt  = 1'b0;
          state_nxt = ST_ACC;
        end
      end

      ST_ACC: begin
        if (!busy_r) begin
          if (tf_r != '0) begin
            dreq.go    = 1'b1;
            dreq.num   = srsg_pkg::DIV_NUM_W'(vdiff_mag) << srsg_pkg::ACC_SHIFT;
            dreq.nbits = srsg_pkg::ACC_BITS;
            dreq.den   = srsg_pkg::DIV_DEN_W'(tf_r);
            busy_nxt   = 1'b1;
          end else begin
            accel_nxt = '0;
          end
        end else if (drsp.done) begin
          busy_nxt  = 1'b0;
          accel_nxt = vdiff[srsg_pkg::VEL_W] ? -$signed(sat_m) : $signed(sat_m);
        end
        if (!busy_r && tf_r == '0 || busy_r && drsp.done) begin
          dir_nxt   = (ent_r.steps > 0) ? 2'sd1 : ((ent_r.steps < 0) ? -2'sd1 : 2'sd0);
          left_nxt  = steps_mag;
          runvi_nxt = ent_r.vi;
          ptime_nxt = '0;
          mult_nxt  = TW'(tp_r);
          dgt_nxt   = 2'(srsg_pkg::MUL_DIGITS - 1);
          start_nxt = 1'b1;
          state_nxt = ST_MUL;
        end
      end

      ST_MUL: begin
        prod_nxt = ((dgt_r == 2'(srsg_pkg::MUL_DIGITS - 1)) ? '0 : (prod_r << 16))
                 + srsg_pkg::PROD_W'(accel_mag * mdigit);
        dgt_nxt  = dgt_r - 1'b1;
        if (dgt_r == '0) begin
          state_nxt = ST_IV;
        end
      end

      ST_IV: begin
        if (!busy_r && vq != '0) begin
          dreq.go    = 1'b1;
          dreq.num   = srsg_pkg::DIV_NUM_W'(1) << (srsg_pkg::DIV_NUM_W - 1);
          dreq.nbits = srsg_pkg::IV_BITS;
          dreq.den   = srsg_pkg::DIV_DEN_W'(vq_mag);
          busy_nxt   = 1'b1;
        end else if (!busy_r || drsp.done) begin
          if (!busy_r) begin
            ival_nxt = start_r ? '0 : (TW'(1) << 32);
          end else begin
            ival_nxt = tf_q[TW-1:0];
          end
          busy_nxt  = 1'b0;
          accum_nxt = acc_sat;
          if (start_r) begin
            pidx_nxt  = pidx_r + 1'b1;
            prem_nxt  = prem_r - 1'b1;
            fin_nxt   = 1'b0;
            start_nxt = 1'b0;
            state_nxt = ST_CMP;
          end else begin
            ptime_nxt = pt_sat;
            act_nxt   = 1'b1;
            state_nxt = ST_OUT;
          end
        end
      end

      ST_CMP: begin
        if (accum_r > ival_r) begin
          accum_nxt = accum_r - ival_r;
          if (left_r != '0) begin
            left_nxt = left_r - 1'b1;
          end
          pulse_nxt = 1'b1;
        end else begin
          pulse_nxt = 1'b0;
        end
        mult_nxt  = ptime_r;
        dgt_nxt   = 2'(srsg_pkg::MUL_DIGITS - 1);
        state_nxt = ST_MUL;
      end

      ST_OUT: begin
        if (!ov_r || out_chan.ready) begin
          ov_nxt     = 1'b1;
          oact_nxt   = act_r;
          opulse_nxt = pulse_r;
          odir_nxt   = dir_r;
          oleft_nxt  = left_r;
          state_nxt  = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      busy_r  <= 1'b0;
      start_r <= 1'b0;
      dgt_r   <= '0;
      pidx_r  <= '0;
      prem_r  <= '0;
      fin_r   <= 1'b0;
      left_r  <= '0;
      dir_r   <= '0;
      accel_r <= '0;
      ptime_r <= '0;
      ival_r  <= '0;
      accum_r <= '0;
      runvi_r <= '0;
      tp_r    <= srsg_pkg::TICK_PERIOD_RST;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= busy_nxt;
      start_r <= start_nxt;
      dgt_r   <= dgt_nxt;
      pidx_r  <= pidx_nxt;
      prem_r  <= prem_nxt;
      fin_r   <= fin_nxt;
      left_r  <= left_nxt;
      dir_r   <= dir_nxt;
      accel_r <= accel_nxt;
      ptime_r <= ptime_nxt;
      ival_r  <= ival_nxt;
      accum_r <= accum_nxt;
      runvi_r <= runvi_nxt;
      ov_r    <= ov_nxt;
      if (cfg_chan.valid) begin
        tp_r <= cfg_chan.data;
      end
    end
    ent_r    <= ent_nxt;
    tf_r     <= tf_nxt;
    mult_r   <= mult_nxt;
    prod_r   <= prod_nxt;
    act_r    <= act_nxt;
    pulse_r  <= pulse_nxt;
    oact_r   <= oact_nxt;
    opulse_r <= opulse_nxt;
    odir_r   <= odir_nxt;
    oleft_r  <= oleft_nxt;
    if (st_we) begin
      store_r[st_wa] <= in_ent;
    end
  end

endmodule
